[rtl/three_phase_spwm_compare_generator_unit_defines.svh]
// Assertion macros for the three-phase SPWM compare generator.
`ifndef THREE_PHASE_SPWM_COMPARE_GENERATOR_UNIT_DEFINES_SVH
`define THREE_PHASE_SPWM_COMPARE_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define TPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds through reset.
`define TPS_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/tpspwm_pkg.sv]
// ----------------------------------------------------------------------------
// tpspwm_pkg
// Types, constants and the sine table of the three-phase SPWM compare generator.
// ----------------------------------------------------------------------------
package tpspwm_pkg;

  localparam int SAMPLES_PER_CYCLE = 192;
  localparam int IDX_W             = $clog2(SAMPLES_PER_CYCLE);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES_PER_CYCLE - 1);
  // phase lags in samples
  localparam logic [IDX_W-1:0] LAG_V    = IDX_W'(SAMPLES_PER_CYCLE / 3);
  localparam logic [IDX_W-1:0] LAG_W    = IDX_W'((2 * SAMPLES_PER_CYCLE) / 3);
  localparam logic [IDX_W-1:0] WRAP_V   = IDX_W'(SAMPLES_PER_CYCLE - SAMPLES_PER_CYCLE / 3);
  localparam logic [IDX_W-1:0] WRAP_W   =
    IDX_W'(SAMPLES_PER_CYCLE - (2 * SAMPLES_PER_CYCLE) / 3);

  // register indexes
  localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
  localparam logic [1:0] REG_MOD_DEPTH   = 2'd1;
  localparam logic [1:0] REG_DEAD_TIME   = 2'd2;

  localparam logic [15:0] HALF_PERIOD_RST = 16'd1000;
  localparam logic [15:0] MOD_DEPTH_RST   = 16'd26214;
  localparam logic [7:0]  DEAD_TIME_RST   = 8'd20;

  // phase slots
  localparam logic [1:0] PH_U = 2'd0;
  localparam logic [1:0] PH_V = 2'd1;
  localparam logic [1:0] PH_W = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_SPAN,
    S_TRIM,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic scale_en;   // t = 2^30 - depth * sample, clamped
    logic span_en;    // high = half_period * t >> 31
  } unit_ctrl_t;

  typedef logic [SAMPLES_PER_CYCLE-1:0][15:0] sine_rom_t;

  // odd 9th-order quarter-wave polynomial, Q28 coefficients
  localparam longint unsigned C1 = 64'd421657428;
  localparam longint unsigned C3 = 64'd173399667;
  localparam longint unsigned C5 = 64'd21392326;
  localparam longint unsigned C7 = 64'd1256749;
  localparam longint unsigned C9 = 64'd43068;

  function automatic logic [15:0] sine_sample(input longint unsigned angle);
    longint unsigned quad;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned p;
    longint unsigned s;
    longint unsigned q15;
    quad = (angle >> 14) & 64'd3;
    x    = angle & 64'h3FFF;
    if (quad[0]) x = 64'd16384 - x;
    x2 = (x * x) >> 14;
    p  = C9;
    p  = C7 - ((x2 * p) >> 14);
    p  = C5 - ((x2 * p) >> 14);
    p  = C3 - ((x2 * p) >> 14);
    p  = C1 - ((x2 * p) >> 14);
    s  = (x * p) >> 14;
    q15 = (s + 64'd4096) >> 13;
    if (q15 > 64'd32767) q15 = 64'd32767;
    if (quad[1]) return 16'(64'd65536 - q15);
    return 16'(q15);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int i = 0; i < SAMPLES_PER_CYCLE; i++) begin
      rom[i] = sine_sample((longint'(i) * 64'd65536) / SAMPLES_PER_CYCLE);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

[rtl/tpspwm_phase_unit.sv]
// ----------------------------------------------------------------------------
// tpspwm_phase_unit
// Shared multiplier with clamp and dead-time trim; each phase passes through it twice.
// ----------------------------------------------------------------------------
module tpspwm_phase_unit import tpspwm_pkg::*; (
  input  logic        clk,
  input  unit_ctrl_t  ctrl,
  input  logic [15:0] sample,       // signed Q1.15 sine value
  input  logic [15:0] half_period,
  input  logic [15:0] mod_depth,
  input  logic [7:0]  dead_time,
  output logic [15:0] high,
  output logic [15:0] low
);

  logic signed [16:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [49:0] prod;
  logic signed [33:0] t_raw;
  logic        [31:0] t_clamp;
  logic        [31:0] t_r;
  logic        [15:0] h_r;

  always_comb begin
    mul_a = ctrl.span_en ? $signed({1'b0, half_period}) : $signed({1'b0, mod_depth});
    mul_b = ctrl.span_en ? $signed({1'b0, t_r}) : $signed({{17{sample[15]}}, sample});
    prod  = mul_a * mul_b;
  end

  always_comb begin
    t_raw = 34'sd1073741824 - 34'(prod);
    if (t_raw[33]) begin
      t_clamp = '0;
    end else if (t_raw > 34'sd2147483648) begin
      t_clamp = 32'h8000_0000;
    end else begin
      t_clamp = t_raw[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.scale_en) t_r <= t_clamp;
    if (ctrl.span_en)  h_r <= prod[46:31];
  end

  assign high = h_r;
  assign low  = (h_r > {8'b0, dead_time}) ? h_r - {8'b0, dead_time} : '0;

endmodule

[rtl/three_phase_spwm_compare_generator_unit.sv]
// ----------------------------------------------------------------------------
// three_phase_spwm_compare_generator_unit
// Three-phase sine PWM compare generator, symmetric regular sampling.
// ----------------------------------------------------------------------------
// Each input transaction with advance set is one carrier-period tick. The block
// reads the sine table for phase U at the current sample index, for V at the
// index less a third of the table and for W at the index less two thirds, and
// returns for each phase the high-side compare half_period*(1 - depth*sin)/2,
// clamped to 0..half_period, and the low-side compare, which is the high-side
// value less dead_time and clamped at 0. sample_index is the index used for U;
// it then moves on by one modulo the table length. A transaction with advance
// clear is taken and gives nothing. For a tick, one multiplier is shared by
// all three phases and each phase passes through it twice (depth scaling,
// then period scaling) and then a trim step; a final hold step, which waits
// while a stalled result is still pending, moves the result to the output
// register. in_tready is high again as soon as the result sits in the output
// register, so the next tick is worked on while that result waits. The sine
// table is a constant built at elaboration; no clearing pass is needed.
// Configuration writes are taken at any time and should be made while idle.
// ----------------------------------------------------------------------------
module three_phase_spwm_compare_generator_unit import tpspwm_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,    // [0] advance, [7:1] zero
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // [15:0] u_high, [31:16] u_low, [47:32] v_high, [63:48] v_low,
  // [79:64] w_high, [95:80] w_low, [103:96] sample_index
  output logic [103:0] out_tdata,
  // configuration
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [15:0]  cfg_wdata
);

  state_t            state_r, state_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [IDX_W-1:0]  step_r, step_nxt;     // next sample index
  logic [IDX_W-1:0]  base_r, base_nxt;     // index of the tick in progress
  logic              out_valid_r, out_valid_nxt;
  logic [103:0]      out_data_r;

  logic [15:0]       half_period_r;
  logic [15:0]       mod_depth_r;
  logic [7:0]        dead_time_r;

  logic [IDX_W-1:0]  rom_idx;
  logic [15:0]       sample;
  unit_ctrl_t        ctrl;
  logic              slot_we;
  logic              out_load;
  logic [15:0]       unit_high;
  logic [15:0]       unit_low;
  logic [15:0]       high_r [3];
  logic [15:0]       low_r  [3];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RST;
      mod_depth_r   <= MOD_DEPTH_RST;
      dead_time_r   <= DEAD_TIME_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_HALF_PERIOD: half_period_r <= cfg_wdata;
        REG_MOD_DEPTH:   mod_depth_r   <= cfg_wdata;
        REG_DEAD_TIME:   dead_time_r   <= cfg_wdata[7:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // lagged table index for the phase in progress
  always_comb begin
    case (phase_r)
      PH_V:    rom_idx = (base_r >= LAG_V) ? base_r - LAG_V : base_r + WRAP_V;
      PH_W:    rom_idx = (base_r >= LAG_W) ? base_r - LAG_W : base_r + WRAP_W;
      default: rom_idx = base_r;
    endcase
  end

  assign sample = SINE_ROM[rom_idx];

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    step_nxt      = step_r;
    base_nxt      = base_r;
    ctrl          = '0;
    slot_we       = 1'b0;
    out_load      = 1'b0;
    in_tready     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && in_tdata[0]) begin
          base_nxt  = step_r;
          step_nxt  = (step_r == LAST_IDX) ? '0 : step_r + 1'b1;
          phase_nxt = PH_U;
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        ctrl.scale_en = 1'b1;
        state_nxt     = S_SPAN;
      end
      S_SPAN: begin
        ctrl.span_en = 1'b1;
        state_nxt    = S_TRIM;
      end
      S_TRIM: begin
        slot_we = 1'b1;
        if (phase_r == PH_W) begin
          state_nxt = S_HOLD;
        end else begin
          phase_nxt = phase_r + 1'b1;
          state_nxt = S_SCALE;
        end
      end
      S_HOLD: begin
        // hand over once the output register is free or being drained
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_U;
      step_r      <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      step_r      <= step_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // per-phase result slots and output register
  always_ff @(posedge clk) begin
    if (slot_we) begin
      high_r[phase_r] <= unit_high;
      low_r[phase_r]  <= unit_low;
    end
    if (out_load) begin
      out_data_r <= {8'(base_r),
                     low_r[PH_W], high_r[PH_W],
                     low_r[PH_V], high_r[PH_V],
                     low_r[PH_U], high_r[PH_U]};
    end
  end

  tpspwm_phase_unit u_phase_unit (
    .clk         (clk),
    .ctrl        (ctrl),
    .sample      (sample),
    .half_period (half_period_r),
    .mod_depth   (mod_depth_r),
    .dead_time   (dead_time_r),
    .high        (unit_high),
    .low         (unit_low)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[rtl/tpspwm_checker.sv]
// ----------------------------------------------------------------------------
// tpspwm_checker
// Port-level checks for the three-phase SPWM compare generator.
// ----------------------------------------------------------------------------
`include "three_phase_spwm_compare_generator_unit_defines.svh"

module tpspwm_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [7:0]   in_tdata,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata
);

  // a stalled result holds
  `TPS_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // low-side compare never exceeds high-side on any phase
  `TPS_ASSERT_IMP(a_low_le_high, clk, rst_n, out_tvalid, (out_tdata[31:16] <= out_tdata[15:0]) && (out_tdata[63:48] <= out_tdata[47:32]) && (out_tdata[95:80] <= out_tdata[79:64]), "low compare above high compare")

  // a tick keeps the input side busy while it is worked on
  `TPS_ASSERT_NXT(a_busy_after_tick, clk, rst_n, in_tvalid && in_tready && in_tdata[0], !in_tready, "input ready right after a tick")

  // no result straight out of reset
  `TPS_ASSERT_NXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_tvalid, "result valid after reset")

endmodule

bind three_phase_spwm_compare_generator_unit tpspwm_checker u_tpspwm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
